// ----- src/rlab_pkg.sv -----
package rlab_pkg;

   localparam int NUM_CH       = 3;
   localparam int PIX_W        = 8;
   localparam int COEF_W       = 14;
   localparam int LMS_W        = COEF_W + PIX_W;
   localparam int EXP_W        = 5;
   localparam int MANT_W       = 32;
   localparam int LOG_FRAC     = 24;
   localparam int LOGU_W       = EXP_W + LOG_FRAC;
   localparam int LOG_W        = LOGU_W + 1;
   localparam int SUM_W        = LOG_W + 2;
   localparam int WEIGHT_W     = 29;
   localparam int WEIGHT_FRAC  = 30;
   localparam int PROD_W       = SUM_W + WEIGHT_W;
   localparam int ACC_W        = PROD_W + 1;
   localparam int OUT_W        = 16;

   localparam int FRACTION_BITS_DEF = 12;

   // pipeline layout: matrix, normalize + one squaring per fraction bit, sum, weight, round
   localparam int LOG_STAGES = LOG_FRAC + 1;
   localparam int OUT_STAGES = 3;
   localparam int NUM_STAGES = 1 + LOG_STAGES + OUT_STAGES;

   typedef logic [PIX_W-1:0]         pix_type;
   typedef logic [LMS_W-1:0]         lms_type;
   typedef logic [LOGU_W-1:0]        logu_type;
   typedef logic signed [OUT_W-1:0]  res_type;

   localparam lms_type LMS_ONE = LMS_W'(10000);

   localparam logic [COEF_W-1:0] LMS_COEF [NUM_CH][NUM_CH] = '{
      '{14'd3811, 14'd5783, 14'd402},
      '{14'd1967, 14'd7244, 14'd782},
      '{14'd241,  14'd1288, 14'd8444}
   };

   // log10(2)/sqrt3, log10(2)/sqrt6, log10(2)/sqrt2 in Q.30
   localparam logic signed [WEIGHT_W-1:0] WEIGHTS [NUM_CH] = '{
      29'sd186616060, 29'sd131957481, 29'sd228557062
   };

   // log2 by repeated squaring, Q.24; used for elaboration-time constants only
   function automatic logic [63:0] log2_q24_calc(input logic [31:0] n);
      logic [63:0] m;
      logic [63:0] frac;
      int          e;
      e = 0;
      for (int i = 0; i < 32; i++) begin
         if (n[i]) e = i;
      end
      m    = {32'd0, n} << (31 - e);
      frac = 64'd0;
      for (int i = 0; i < LOG_FRAC; i++) begin
         m    = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 64'd1;
            m    = m >> 1;
         end
      end
      return (64'(e) << LOG_FRAC) | frac;
   endfunction

   localparam logu_type REF_LOG = LOGU_W'(log2_q24_calc(32'd10000));

endpackage

// ----- src/rlab_lms.sv -----
module rlab_lms import rlab_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  pix_type px [NUM_CH],
   output lms_type lms [NUM_CH]
);

   lms_type lms_in [NUM_CH];
   lms_type lms_ff [NUM_CH];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         lms_in[c] = LMS_W'(0);
         for (int k = 0; k < NUM_CH; k++) begin
            lms_in[c] = lms_in[c] + LMS_W'(LMS_W'(LMS_COEF[c][k]) * LMS_W'(px[k]));
         end
         // black pixel: force channel to 1.0 so its log is zero
         if (lms_in[c] == LMS_W'(0)) lms_in[c] = LMS_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) lms_ff <= lms_in;
   end

   assign lms = lms_ff;

endmodule

// ----- src/rlab_log.sv -----
module rlab_log import rlab_pkg::*; (
   input  logic                  clock,
   input  logic [LOG_STAGES-1:0] en,
   input  lms_type               lms [NUM_CH],
   output logu_type              lg [NUM_CH]
);

   logic [MANT_W-1:0]   m_in    [LOG_STAGES][NUM_CH];
   logic [EXP_W-1:0]    e_in    [LOG_STAGES][NUM_CH];
   logic [LOG_FRAC-1:0] frac_in [LOG_STAGES][NUM_CH];
   logic [MANT_W-1:0]   m_ff    [LOG_STAGES][NUM_CH];
   logic [EXP_W-1:0]    e_ff    [LOG_STAGES][NUM_CH];
   logic [LOG_FRAC-1:0] frac_ff [LOG_STAGES][NUM_CH];

   always_comb begin
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     t;
      // stage 0: leading-one position and mantissa normalized to Q1.31
      for (int c = 0; c < NUM_CH; c++) begin
         e_in[0][c] = EXP_W'(0);
         for (int i = 0; i < LMS_W; i++) begin
            if (lms[c][i]) e_in[0][c] = EXP_W'(i);
         end
         m_in[0][c]    = MANT_W'(lms[c]) << (EXP_W'(MANT_W - 1) - e_in[0][c]);
         frac_in[0][c] = '0;
      end
      // one squaring per stage; a square reaching 2.0 yields a 1 bit and is halved
      for (int s = 1; s < LOG_STAGES; s++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            sq = {{MANT_W{1'b0}}, m_ff[s-1][c]} * {{MANT_W{1'b0}}, m_ff[s-1][c]};
            t  = sq[2*MANT_W-1:MANT_W-1];
            m_in[s][c]    = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
            e_in[s][c]    = e_ff[s-1][c];
            frac_in[s][c] = {frac_ff[s-1][c][LOG_FRAC-2:0], t[MANT_W]};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < LOG_STAGES; s++) begin
         if (en[s]) begin
            m_ff[s]    <= m_in[s];
            e_ff[s]    <= e_in[s];
            frac_ff[s] <= frac_in[s];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         lg[c] = {e_ff[LOG_STAGES-1][c], frac_ff[LOG_STAGES-1][c]};
      end
   end

endmodule

// ----- src/rlab_comb.sv -----
module rlab_comb import rlab_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                  clock,
   input  logic [OUT_STAGES-1:0] en,
   input  logu_type              lg [NUM_CH],
   output res_type               res [NUM_CH]
);

   localparam int SH = LOG_FRAC + WEIGHT_FRAC - FRACTION_BITS;
   localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (SH - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2**(OUT_W-1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2**(OUT_W-1)));

   logic signed [LOG_W-1:0]  lgs     [NUM_CH];
   logic signed [SUM_W-1:0]  sum_in  [NUM_CH];
   logic signed [SUM_W-1:0]  sum_ff  [NUM_CH];
   logic signed [PROD_W-1:0] prod_in [NUM_CH];
   logic signed [PROD_W-1:0] prod_ff [NUM_CH];
   logic signed [ACC_W-1:0]  rnd     [NUM_CH];
   logic signed [ACC_W-1:0]  shr     [NUM_CH];
   res_type                  res_in  [NUM_CH];
   res_type                  res_ff  [NUM_CH];

   // log2 of the channel value: subtract log2 of the 10000 scale
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         lgs[c] = $signed({1'b0, lg[c]}) - $signed({1'b0, REF_LOG});
      end
      sum_in[0] = SUM_W'(lgs[0]) + SUM_W'(lgs[1]) + SUM_W'(lgs[2]);
      sum_in[1] = SUM_W'(lgs[0]) + SUM_W'(lgs[1]) - (SUM_W'(lgs[2]) <<< 1);
      sum_in[2] = SUM_W'(lgs[0]) - SUM_W'(lgs[1]);
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod_in[c] = sum_ff[c] * WEIGHTS[c];
      end
   end

   // round half up, then saturate to 16 bits
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         rnd[c] = ACC_W'(prod_ff[c]) + HALF;
         shr[c] = rnd[c] >>> SH;
         if (shr[c] > SAT_HI)      res_in[c] = OUT_W'(SAT_HI);
         else if (shr[c] < SAT_LO) res_in[c] = OUT_W'(SAT_LO);
         else                      res_in[c] = OUT_W'(shr[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) sum_ff  <= sum_in;
      if (en[1]) prod_ff <= prod_in;
      if (en[2]) res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

// ----- src/rgb_to_lalphabeta_converter.sv -----
// Stages from a req transfer to rsp_tvalid: 1 matrix stage, 1 normalize
// stage, 24 squaring stages, then sum, weight and round stages.
// Throughput: one pixel per cycle; each stage advances on its own, so bubbles close
// up under a stalled rsp side and req_tready stays high until every stage is full.
// Reset clears the stage valid bits only; data registers are not reset.
module rgb_to_lalphabeta_converter import rlab_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // lightness[15:0], alpha[31:16], beta[47:32]
);

   logic [NUM_STAGES-1:0] v_ff;
   logic [NUM_STAGES-1:0] v_in;
   logic [NUM_STAGES-1:0] en;

   pix_type  px  [NUM_CH];
   lms_type  lms [NUM_CH];
   logu_type lg  [NUM_CH];
   res_type  res [NUM_CH];

   // a stage may load when rsp_tready is high or when it or any stage downstream holds a bubble
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
      assign en[i] = rsp_tready | ~(&v_ff[NUM_STAGES-1:i]);
   end

   assign v_in = {v_ff[NUM_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= (v_ff & ~en) | (v_in & en);
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NUM_STAGES-1];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         px[c] = req_tdata[c*PIX_W +: PIX_W];
      end
   end

   rlab_lms u_lms (
      .clock (clock),
      .en    (en[0]),
      .px    (px),
      .lms   (lms)
   );

   rlab_log u_log (
      .clock (clock),
      .en    (en[LOG_STAGES:1]),
      .lms   (lms),
      .lg    (lg)
   );

   rlab_comb #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_comb (
      .clock (clock),
      .en    (en[NUM_STAGES-1:LOG_STAGES+1]),
      .lg    (lg),
      .res   (res)
   );

   assign rsp_tdata = {res[2], res[1], res[0]};

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted pixel did not enter the first stage");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && !rsp_tready) |-> !req_tready)
      else $error("full pipeline still accepting under a stalled output");

   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while the output stage is empty");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !v_ff[NUM_STAGES-2]) |=> !rsp_tvalid)
      else $error("output stayed valid without a pixel behind it");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule
